@@ hw/rtl/wrp_pkg.sv @@
package wrp_pkg;

  // Result event codes
  typedef enum logic [2:0] {
    EV_CONSUMED     = 3'd0,
    EV_STREAM_START = 3'd1,
    EV_PAYLOAD      = 3'd2,
    EV_NOT_RIFF     = 3'd3,
    EV_UNSUPPORTED  = 3'd4,
    EV_INVALID      = 3'd5,
    EV_IGNORED      = 3'd6
  } event_t;

  localparam logic [31:0] TAG_FMT     = 32'h666D7420;  // "fmt "
  localparam logic [31:0] TAG_DATA    = 32'h64617461;  // "data"
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [15:0] PCM_CODE    = 16'd1;
  localparam logic [15:0] PCM_BITS    = 16'd16;
  localparam logic [4:0]  HDR_LEN     = 5'd12;
  localparam logic [4:0]  CHUNK_HDR_LAST = 5'd7;
  localparam logic [4:0]  FMT_BODY_LAST  = 5'd15;

  // One result request
  typedef struct packed {
    event_t      ev;
    logic [7:0]  pay;
    logic [30:0] sr;
    logic [1:0]  ch;
    logic [31:0] dl;
    logic [31:0] bp;
    logic        last;
  } result_t;

  // Expected RIFF/WAVE header bytes; size bytes are not checked
  function automatic logic [7:0] hdr_expect(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h52;  // R
      4'd1:    v = 8'h49;  // I
      4'd2:    v = 8'h46;  // F
      4'd3:    v = 8'h46;  // F
      4'd8:    v = 8'h57;  // W
      4'd9:    v = 8'h41;  // A
      4'd10:   v = 8'h56;  // V
      4'd11:   v = 8'h45;  // E
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/wrp_parse.sv @@
module wrp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             start_of_file,
  input  logic             end_of_file,
  output wrp_pkg::result_t res
);
  import wrp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF, PH_CHUNK, PH_FMT, PH_SKIP, PH_PAYLOAD, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  field_count, field_count_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] down_count, down_count_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] bit_width, bit_width_next;
  logic [31:0] payload_count, payload_count_next;

  // state as seen by this byte (start_of_file restarts it)
  phase_t      ph_b;
  logic [4:0]  fc_b;
  logic [31:0] tag_b, len_b, down_b, rate_b, pc_b;
  logic [15:0] fmt_b, chan_b, bw_b;
  logic [31:0] down_dec;
  logic        rate_bad, chan_bad;

  always_comb begin
    ph_b   = start_of_file ? PH_RIFF : phase;
    fc_b   = start_of_file ? 5'd0 : field_count;
    tag_b  = start_of_file ? 32'd0 : chunk_tag;
    len_b  = start_of_file ? 32'd0 : chunk_length;
    down_b = start_of_file ? 32'd0 : down_count;
    fmt_b  = start_of_file ? 16'd0 : format_code;
    chan_b = start_of_file ? 16'd1 : channels_seen;
    rate_b = start_of_file ? 32'd0 : rate_seen;
    bw_b   = start_of_file ? 16'd16 : bit_width;
    pc_b   = start_of_file ? 32'd0 : payload_count;
    down_dec = down_b - 32'd1;
    rate_bad = (rate_b == 32'd0) || rate_b[31];
    chan_bad = (chan_b < 16'd1) || (chan_b > 16'd2);

    phase_next         = ph_b;
    field_count_next   = fc_b;
    chunk_tag_next     = tag_b;
    chunk_length_next  = len_b;
    down_count_next    = down_b;
    format_code_next   = fmt_b;
    channels_seen_next = chan_b;
    rate_seen_next     = rate_b;
    bit_width_next     = bw_b;
    payload_count_next = pc_b;

    res      = '0;
    res.ev   = EV_CONSUMED;

    unique case (ph_b)
      PH_RIFF: begin
        if (fc_b >= HDR_LEN ||
            ((fc_b < 5'd4 || fc_b >= 5'd8) && data_byte != hdr_expect(fc_b[3:0]))) begin
          res.ev = EV_NOT_RIFF; res.last = 1'b1; phase_next = PH_DONE;
        end else if (fc_b == HDR_LEN - 5'd1) begin
          phase_next = PH_CHUNK; field_count_next = 5'd0;
        end else begin
          field_count_next = fc_b + 5'd1;
        end
      end
      PH_CHUNK: begin
        if (fc_b < 5'd4) begin
          chunk_tag_next = {tag_b[23:0], data_byte};
          if (fc_b == 5'd0) chunk_length_next = 32'd0;
          field_count_next = fc_b + 5'd1;
        end else begin
          // length lanes were cleared at the first tag byte
          chunk_length_next[{fc_b[1:0], 3'b000} +: 8] = data_byte;
          if (fc_b < CHUNK_HDR_LAST) begin
            field_count_next = fc_b + 5'd1;
          end else if (tag_b == TAG_FMT) begin
            if (chunk_length_next < FMT_MIN_LEN) begin
              res.ev = EV_INVALID; res.last = 1'b1; phase_next = PH_DONE;
            end else begin
              phase_next = PH_FMT; field_count_next = 5'd0;
            end
          end else if (tag_b == TAG_DATA) begin
            if (rate_bad || chan_bad) begin
              res.ev = EV_INVALID; res.last = 1'b1; phase_next = PH_DONE;
            end else begin
              res.ev = EV_STREAM_START;
              res.sr = rate_b[30:0];
              res.ch = chan_b[1:0];
              res.dl = chunk_length_next;
              down_count_next = chunk_length_next;
              if (chunk_length_next == 32'd0 || end_of_file) begin
                res.last = 1'b1; phase_next = PH_DONE;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end else begin
            down_count_next = chunk_length_next;
            if (chunk_length_next == 32'd0) begin
              phase_next = PH_CHUNK; field_count_next = 5'd0;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_FMT: begin
        case (fc_b) inside
          5'd0:  format_code_next   = {8'h00, data_byte};
          5'd1:  format_code_next   = {data_byte, fmt_b[7:0]};
          5'd2:  channels_seen_next = {8'h00, data_byte};
          5'd3:  channels_seen_next = {data_byte, chan_b[7:0]};
          5'd4:  rate_seen_next     = {24'h0, data_byte};
          [5'd5:5'd7]: rate_seen_next[{fc_b[1:0], 3'b000} +: 8] = data_byte;
          5'd14: bit_width_next     = {8'h00, data_byte};
          5'd15: bit_width_next     = {data_byte, bw_b[7:0]};
          default: ;
        endcase
        if (fc_b < FMT_BODY_LAST) begin
          field_count_next = fc_b + 5'd1;
        end else if (format_code_next != PCM_CODE || bit_width_next != PCM_BITS) begin
          res.ev = EV_UNSUPPORTED; res.last = 1'b1; phase_next = PH_DONE;
        end else if (len_b > FMT_MIN_LEN) begin
          down_count_next = len_b - FMT_MIN_LEN;
          phase_next = PH_SKIP;
        end else begin
          phase_next = PH_CHUNK; field_count_next = 5'd0;
        end
      end
      PH_SKIP: begin
        down_count_next = down_dec;
        if (down_dec == 32'd0) begin
          phase_next = PH_CHUNK; field_count_next = 5'd0;
        end
      end
      PH_PAYLOAD: begin
        res.ev = EV_PAYLOAD;
        res.pay = data_byte;
        payload_count_next = pc_b + 32'd1;
        down_count_next = down_dec;
        if (down_dec == 32'd0 || end_of_file) begin
          res.last = 1'b1; phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        res.ev = EV_IGNORED;
      end
      default: begin
        res.ev = EV_IGNORED;
        phase_next = PH_DONE;
      end
    endcase

    // file ended before its natural end
    if (end_of_file && phase_next != PH_DONE) begin
      res.ev = (phase_next == PH_RIFF) ? EV_NOT_RIFF : EV_INVALID;
      res.last = 1'b1;
      phase_next = PH_DONE;
    end

    res.bp = payload_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RIFF;
      field_count   <= 5'd0;
      chunk_tag     <= 32'd0;
      chunk_length  <= 32'd0;
      down_count    <= 32'd0;
      format_code   <= 16'd0;
      channels_seen <= 16'd1;
      rate_seen     <= 32'd0;
      bit_width     <= 16'd16;
      payload_count <= 32'd0;
    end else if (accept) begin
      phase         <= phase_next;
      field_count   <= field_count_next;
      chunk_tag     <= chunk_tag_next;
      chunk_length  <= chunk_length_next;
      down_count    <= down_count_next;
      format_code   <= format_code_next;
      channels_seen <= channels_seen_next;
      rate_seen     <= rate_seen_next;
      bit_width     <= bit_width_next;
      payload_count <= payload_count_next;
    end
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    accept && res.last |=> phase == PH_DONE)
    else $error("final event did not end the file");

  a_fc_range: assert property (@(posedge clk) disable iff (rst)
    field_count <= FMT_BODY_LAST)
    else $error("field counter out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    accept && res.ev == EV_PAYLOAD |-> res.bp != 32'd0)
    else $error("payload byte with zero pass count");

endmodule

@@ hw/rtl/wrp_fifo.sv @@
module wrp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  wrp_pkg::result_t wr_data,
  input  logic             rd_en,
  output wrp_pkg::result_t rd_data,
  output logic             full,
  output logic             empty
);
  import wrp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue overfilled");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + CW'(1))
    else $error("write lost");

  a_shrink: assert property (@(posedge clk) disable iff (rst)
    do_rd && !do_wr |=> count == $past(count) - CW'(1))
    else $error("read not retired");

endmodule

@@ hw/rtl/wav_riff_stream_parser_core.sv @@
// Channel   | Handshake          | Payload
// ----------+--------------------+--------------------------------------------------
// bytes in  | push / full        | data_byte, start_of_file, end_of_file
// events out| pop / empty        | event_res, payload_byte, sample_rate, channel_count,
//           |                    | data_length, bytes_passed, last
//
// One byte is parsed per cycle: every accepted byte yields exactly one event request.
// The parser state update is combinational logic (32-bit compare/decrement) into
// registers, so a new byte can be pushed every cycle while the event queue has room.
// Each event is written into the queue and reaches its head after earlier events pop.
// A stall on the pop side fills the QUEUE_DEPTH-entry event queue, then raises full.
// rst (synchronous) empties the queue and returns the parser to the RIFF header.
module wav_riff_stream_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // byte side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  input  logic        end_of_file,
  // event side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [30:0] sample_rate,
  output logic [1:0]  channel_count,
  output logic [31:0] data_length,
  output logic [31:0] bytes_passed,
  output logic        last
);
  import wrp_pkg::*;

  result_t parse_res;   // event for the byte being accepted
  result_t head;        // oldest queued event
  logic    accept;

  // a byte is taken only when its event has a slot waiting
  assign accept = push && !full;

  // Front: byte classifier and RIFF/fmt/data state machine
  wrp_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .end_of_file   (end_of_file),
    .res           (parse_res)
  );

  // Back: event queue decoupling the parser from the consumer
  wrp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (parse_res),
    .rd_en   (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign event_res     = head.ev;
  assign payload_byte  = head.pay;
  assign sample_rate   = head.sr;
  assign channel_count = head.ch;
  assign data_length   = head.dl;
  assign bytes_passed  = head.bp;
  assign last          = head.last;

endmodule
